FILE: rtl/core/tpsv_pkg.sv
package tpsv_pkg;

  // Field widths
  localparam int unsigned TRIG_W    = 18;
  localparam int unsigned POINT_W   = 24;
  localparam int unsigned SKY_W     = 22;
  localparam int unsigned CFG_IDX_W = 3;

  // Internal datapath widths
  localparam int unsigned SUMSQ_W    = 52;  // rx^2 + ry^2 + 1.0 in Q.40
  localparam int unsigned MAG_W      = 47;  // magnitude of a numerator
  localparam int unsigned DEN_W      = 27;  // square root in Q.20
  localparam int unsigned DVS_W      = 28;  // twice the root
  localparam int unsigned REM_W      = 53;  // rounded dividend
  localparam int unsigned QUO_W      = 22;  // quotient bits per lane
  localparam int unsigned ROOT_STEPS = 26;
  localparam int unsigned ROOT_TOP   = 50;  // bit of the first root trial

  localparam logic [QUO_W-1:0] ONE_Q20 = 22'd1048576;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COS_ROT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_ROT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_TILT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_TILT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COS_SPIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_SPIN = 3'd5;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 18'sd65536;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO = 18'sd0;

  typedef struct packed {
    logic signed [TRIG_W-1:0] cos_rot;
    logic signed [TRIG_W-1:0] sin_rot;
    logic signed [TRIG_W-1:0] cos_tilt;
    logic signed [TRIG_W-1:0] sin_tilt;
    logic signed [TRIG_W-1:0] cos_spin;
    logic signed [TRIG_W-1:0] sin_spin;
  } trig_set_t;

  // Numerators in sign/magnitude plus the radicand, lanes x, y, z
  typedef struct packed {
    logic [SUMSQ_W-1:0]        sumsq;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
  } front_beat_t;

  typedef struct packed {
    logic [SUMSQ_W-1:0]        rem;
    logic [SUMSQ_W-1:0]        res;
    logic [2:0]                neg;
    logic [2:0][MAG_W-1:0]     mag;
  } root_beat_t;

  typedef struct packed {
    logic [DVS_W-1:0]          dvs;
    logic [2:0][REM_W-1:0]     rem;
    logic [2:0][QUO_W-1:0]     quo;
    logic [2:0]                sat;
    logic [2:0]                neg;
  } div_beat_t;

endpackage

FILE: rtl/core/tpsv_point_if.sv
interface tpsv_point_if;
  logic                valid;
  logic                ready;
  logic signed [23:0]  point_x;
  logic signed [23:0]  point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

FILE: rtl/core/tpsv_sky_if.sv
interface tpsv_sky_if;
  logic                valid;
  logic                ready;
  logic signed [21:0]  sky_x;
  logic signed [21:0]  sky_y;
  logic signed [21:0]  sky_z;

  modport source (output valid, sky_x, sky_y, sky_z, input ready);
  modport sink   (input valid, sky_x, sky_y, sky_z, output ready);
endinterface

FILE: rtl/core/tpsv_cfg_if.sv
interface tpsv_cfg_if;
  logic                valid;
  logic                ready;
  logic [2:0]          index;
  logic signed [17:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/tpsv_front.sv
module tpsv_front
  import tpsv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [POINT_W-1:0] point_x,
  input  logic signed [POINT_W-1:0] point_y,
  input  trig_set_t                 trig,
  output logic                      out_valid,
  output front_beat_t               out_beat
);

  logic [6:0] v_r;

  // stage 1: rotator products
  logic signed [41:0] p_cx_r, p_sy_r, p_cy_r, p_sx_r;
  // stage 2: rotated point in Q.20
  logic signed [26:0] rx_r, ry_r;
  // stage 3: squares and tilt/spin products
  logic [50:0]        sqx_r, sqy_r;
  logic signed [44:0] ryct_r, ryst_r, rxcs3_r, rxss3_r;
  // stage 4: radicand, tilted y and z in Q.36
  logic [SUMSQ_W-1:0] sumsq4_r;
  logic signed [44:0] sy_r, sz4_r, rxcs4_r, rxss4_r;
  // stage 5: split products of sy with the spin terms
  logic [SUMSQ_W-1:0] sumsq5_r;
  logic signed [44:0] sz5_r, rxcs5_r, rxss5_r;
  logic signed [40:0] hi_ss_r, lo_ss_r, hi_cs_r, lo_cs_r;
  // stage 6: spun x and y in Q.36
  logic [SUMSQ_W-1:0] sumsq6_r;
  logic signed [44:0] sz6_r;
  logic [47:0]        ox_r, oy_r;
  // stage 7: sign and magnitude
  front_beat_t        beat_r;

  logic [42:0] sum_x, sum_y;
  logic signed [53:0] sqx_full, sqy_full;
  logic signed [22:0] sy_hi, sy_lo;
  logic [63:0] ox_full, oy_full;
  logic [47:0] sz_ext;
  logic [47:0] mx, my, mz;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], in_valid};
    end
  end

  always_comb begin
    sum_x    = {p_cx_r[41], p_cx_r} + {p_sy_r[41], p_sy_r} + 43'd32768;
    sum_y    = {p_cy_r[41], p_cy_r} - {p_sx_r[41], p_sx_r} + 43'd32768;
    sqx_full = rx_r * rx_r;
    sqy_full = ry_r * ry_r;
    sy_hi    = $signed(sy_r[44:22]);
    sy_lo    = $signed({1'b0, sy_r[21:0]});
    ox_full  = {{3{rxcs5_r[44]}}, rxcs5_r, 16'd0}
             - {hi_ss_r[40], hi_ss_r, 22'd0}
             - {{23{lo_ss_r[40]}}, lo_ss_r} + 64'd32768;
    oy_full  = {{3{rxss5_r[44]}}, rxss5_r, 16'd0}
             + {hi_cs_r[40], hi_cs_r, 22'd0}
             + {{23{lo_cs_r[40]}}, lo_cs_r} + 64'd32768;
    sz_ext   = {{3{sz6_r[44]}}, sz6_r};
    mx       = ox_r[47]   ? (48'd0 - ox_r)   : ox_r;
    my       = oy_r[47]   ? (48'd0 - oy_r)   : oy_r;
    mz       = sz_ext[47] ? (48'd0 - sz_ext) : sz_ext;
  end

  // Payload stages hold while stalled
  always_ff @(posedge clk) begin
    if (en) begin
      p_cx_r   <= trig.cos_rot * point_x;
      p_sy_r   <= trig.sin_rot * point_y;
      p_cy_r   <= trig.cos_rot * point_y;
      p_sx_r   <= trig.sin_rot * point_x;

      rx_r     <= $signed(sum_x[42:16]);
      ry_r     <= $signed(sum_y[42:16]);

      sqx_r    <= sqx_full[50:0];
      sqy_r    <= sqy_full[50:0];
      ryct_r   <= ry_r * trig.cos_tilt;
      ryst_r   <= ry_r * trig.sin_tilt;
      rxcs3_r  <= rx_r * trig.cos_spin;
      rxss3_r  <= rx_r * trig.sin_spin;

      sumsq4_r <= {1'b0, sqx_r} + {1'b0, sqy_r} + (52'd1 << 40);
      sy_r     <= ryct_r - {{7{trig.sin_tilt[17]}}, trig.sin_tilt, 20'd0};
      sz4_r    <= ryst_r + {{7{trig.cos_tilt[17]}}, trig.cos_tilt, 20'd0};
      rxcs4_r  <= rxcs3_r;
      rxss4_r  <= rxss3_r;

      sumsq5_r <= sumsq4_r;
      sz5_r    <= sz4_r;
      rxcs5_r  <= rxcs4_r;
      rxss5_r  <= rxss4_r;
      hi_ss_r  <= sy_hi * trig.sin_spin;
      lo_ss_r  <= sy_lo * trig.sin_spin;
      hi_cs_r  <= sy_hi * trig.cos_spin;
      lo_cs_r  <= sy_lo * trig.cos_spin;

      sumsq6_r <= sumsq5_r;
      sz6_r    <= sz5_r;
      ox_r     <= ox_full[63:16];
      oy_r     <= oy_full[63:16];

      beat_r.sumsq  <= sumsq6_r;
      beat_r.neg    <= {sz_ext[47], oy_r[47], ox_r[47]};
      beat_r.mag[0] <= mx[MAG_W-1:0];
      beat_r.mag[1] <= my[MAG_W-1:0];
      beat_r.mag[2] <= mz[MAG_W-1:0];
    end
  end

  assign out_valid = v_r[6];
  assign out_beat  = beat_r;

endmodule

FILE: rtl/core/tpsv_root_step.sv
module tpsv_root_step
  import tpsv_pkg::*;
#(
  parameter int unsigned BIT_POS = 50
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  root_beat_t in_beat,
  output logic       out_valid,
  output root_beat_t out_beat
);

  localparam logic [SUMSQ_W-1:0] BIT_VAL = SUMSQ_W'(1) << BIT_POS;

  logic       v_r;
  root_beat_t beat_r;
  root_beat_t beat_nxt;
  logic [SUMSQ_W-1:0] trial;

  // One trial subtraction of the bitwise square root
  always_comb begin
    trial    = in_beat.res + BIT_VAL;
    beat_nxt = in_beat;
    if (in_beat.rem >= trial) begin
      beat_nxt.rem = in_beat.rem - trial;
      beat_nxt.res = (in_beat.res >> 1) + BIT_VAL;
    end else begin
      beat_nxt.res = in_beat.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/core/tpsv_div_step.sv
module tpsv_div_step
  import tpsv_pkg::*;
#(
  parameter int unsigned BIT_POS = 21
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_beat_t in_beat,
  output logic      out_valid,
  output div_beat_t out_beat
);

  logic      v_r;
  div_beat_t beat_r;
  div_beat_t beat_nxt;
  logic [REM_W-1:0] shifted;

  // One quotient bit in each of the three lanes
  always_comb begin
    shifted  = {{(REM_W-DVS_W){1'b0}}, in_beat.dvs} << BIT_POS;
    beat_nxt = in_beat;
    for (int i = 0; i < 3; i++) begin
      if (in_beat.rem[i] >= shifted) begin
        beat_nxt.rem[i]          = in_beat.rem[i] - shifted;
        beat_nxt.quo[i][BIT_POS] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_beat  = beat_r;

endmodule

FILE: rtl/core/tangent_plane_to_sky_vector.sv
// Inverse gnomonic projection: one focal-plane point (Q3.20) in, one sky
// unit vector (three Q1.20 components, saturated to +-1.0) out.
// Channels: in_pt takes a point beat, out_sky gives the vector beat, both
// valid/ready. cfg_wr writes the six Q1.16 trig registers (rotator, tilt,
// spin, cosine then sine); it is always ready and ignores indexes 6 and 7.
// Write the registers only while no point is in flight.
// Pipeline from an accepted point to its vector on out_sky: seven stages
// of rotation products, 26 square-root stages (one root bit each), one
// divider setup stage, 22 divider stages (one quotient bit each for all
// three lanes) and the output register.
// Throughput: one point per cycle unless stalled; the pipeline advances as one.
// Stall: a two-entry output buffer lets the pipeline take one more beat
// after out_sky stops; in_pt.ready then drops until the buffer drains.
// in_pt.ready comes from a register only.
// Reset (rst_n low, synchronous): pipeline and output are emptied, the
// cosines go to 1.0 and the sines to 0.
module tangent_plane_to_sky_vector
  import tpsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tpsv_point_if.sink  in_pt,
  tpsv_sky_if.source  out_sky,
  tpsv_cfg_if.sink    cfg_wr
);

  trig_set_t   trig_r;
  logic        en;
  logic        out_valid_r, skid_valid_r;
  logic signed [SKY_W-1:0] out_x_r, out_y_r, out_z_r;
  logic signed [SKY_W-1:0] skid_x_r, skid_y_r, skid_z_r;

  logic        front_v;
  front_beat_t front_b;
  logic        root_v [0:ROOT_STEPS];
  root_beat_t  root_b [0:ROOT_STEPS];
  logic        div_v  [0:QUO_W];
  div_beat_t   div_b  [0:QUO_W];
  div_beat_t   setup_nxt;
  logic [DEN_W-1:0] den;
  logic [REM_W-1:0] dividend [0:2];
  logic [2:0][SKY_W-1:0] res_nxt;
  logic [QUO_W-1:0] qsat;
  logic        last_v;
  logic        div_v0_r;
  div_beat_t   div_b0_r;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_r.cos_rot  <= TRIG_ONE;
      trig_r.sin_rot  <= TRIG_ZERO;
      trig_r.cos_tilt <= TRIG_ONE;
      trig_r.sin_tilt <= TRIG_ZERO;
      trig_r.cos_spin <= TRIG_ONE;
      trig_r.sin_spin <= TRIG_ZERO;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_COS_ROT:  trig_r.cos_rot  <= cfg_wr.data;
        REG_SIN_ROT:  trig_r.sin_rot  <= cfg_wr.data;
        REG_COS_TILT: trig_r.cos_tilt <= cfg_wr.data;
        REG_SIN_TILT: trig_r.sin_tilt <= cfg_wr.data;
        REG_COS_SPIN: trig_r.cos_spin <= cfg_wr.data;
        REG_SIN_SPIN: trig_r.sin_spin <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Whole pipeline advances while the output buffer has room
  assign en          = !skid_valid_r;
  assign in_pt.ready = en;

  tpsv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_pt.valid),
    .point_x   (in_pt.point_x),
    .point_y   (in_pt.point_y),
    .trig      (trig_r),
    .out_valid (front_v),
    .out_beat  (front_b)
  );

  // Square root of the radicand, one bit per stage
  assign root_v[0] = front_v;
  assign root_b[0] = '{rem: front_b.sumsq, res: '0, neg: front_b.neg, mag: front_b.mag};

  for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
    tpsv_root_step #(
      .BIT_POS (ROOT_TOP - 2 * g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (root_v[g]),
      .in_beat   (root_b[g]),
      .out_valid (root_v[g+1]),
      .out_beat  (root_b[g+1])
    );
  end

  // Divider setup: rounded dividend 32*mag + den over 2*den, early overflow
  always_comb begin
    den           = root_b[ROOT_STEPS].res[DEN_W-1:0];
    setup_nxt.dvs = {den, 1'b0};
    setup_nxt.neg = root_b[ROOT_STEPS].neg;
    setup_nxt.quo = '0;
    for (int i = 0; i < 3; i++) begin
      dividend[i] = {1'b0, root_b[ROOT_STEPS].mag[i], 5'd0}
                  + {{(REM_W-DEN_W){1'b0}}, den};
      setup_nxt.rem[i] = dividend[i];
      setup_nxt.sat[i] = dividend[i] >= {3'd0, setup_nxt.dvs, 22'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v0_r <= 1'b0;
    end else if (en) begin
      div_v0_r <= root_v[ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_b0_r <= setup_nxt;
    end
  end

  assign div_v[0] = div_v0_r;
  assign div_b[0] = div_b0_r;

  for (genvar g = 0; g < QUO_W; g++) begin : g_div
    tpsv_div_step #(
      .BIT_POS (QUO_W - 1 - g)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (div_v[g]),
      .in_beat   (div_b[g]),
      .out_valid (div_v[g+1]),
      .out_beat  (div_b[g+1])
    );
  end

  // Saturate to one and restore the sign
  always_comb begin
    last_v = div_v[QUO_W];
    qsat   = '0;
    for (int i = 0; i < 3; i++) begin
      if (div_b[QUO_W].sat[i] || (div_b[QUO_W].quo[i] > ONE_Q20)) begin
        qsat = ONE_Q20;
      end else begin
        qsat = div_b[QUO_W].quo[i];
      end
      res_nxt[i] = div_b[QUO_W].neg[i] ? (SKY_W'(0) - qsat) : qsat;
    end
  end

  // Output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && out_sky.ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= last_v && en;
      end
    end else if (!out_valid_r) begin
      out_valid_r <= last_v && en;
    end else if (last_v && en) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_sky.ready && skid_valid_r) begin
      out_x_r <= skid_x_r;
      out_y_r <= skid_y_r;
      out_z_r <= skid_z_r;
    end else if ((!out_valid_r || out_sky.ready) && last_v && en) begin
      out_x_r <= res_nxt[0];
      out_y_r <= res_nxt[1];
      out_z_r <= res_nxt[2];
    end
    if (out_valid_r && !out_sky.ready && last_v && en) begin
      skid_x_r <= res_nxt[0];
      skid_y_r <= res_nxt[1];
      skid_z_r <= res_nxt[2];
    end
  end

  assign out_sky.valid = out_valid_r;
  assign out_sky.sky_x = out_x_r;
  assign out_sky.sky_y = out_y_r;
  assign out_sky.sky_z = out_z_r;

  // The skid entry is only ever filled behind a held output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid without output beat");

  // A beat landing in the skid entry stops the input side
  a_skid_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_sky.ready && last_v && en) |=> !in_pt.ready)
    else $error("input still ready with skid entry full");

  // The x and z results stay within plus or minus one
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_x_r <= 22'sd1048576) && (out_x_r >= -22'sd1048576) &&
                     (out_z_r <= 22'sd1048576) && (out_z_r >= -22'sd1048576)))
    else $error("sky component beyond saturation bound");

endmodule

FILE: bench/tangent_plane_to_sky_vector_tb.sv
module tangent_plane_to_sky_vector_tb
  import tpsv_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [SKY_W-1:0] sky_x;
    logic signed [SKY_W-1:0] sky_y;
    logic signed [SKY_W-1:0] sky_z;
  } sky_vec_t;

  typedef struct {
    logic signed [POINT_W-1:0] point_x;
    logic signed [POINT_W-1:0] point_y;
  } corner_t;

  localparam int DRAIN_CYCLES = 70;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  tpsv_point_if pt_if ();
  tpsv_sky_if   sky_if ();
  tpsv_cfg_if   cfg_if ();

  tangent_plane_to_sky_vector u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pt   (pt_if),
    .out_sky (sky_if),
    .cfg_wr  (cfg_if)
  );

  // trig registers as the block should hold them
  logic signed [TRIG_W-1:0] trig_regs [6];

  corner_t  corner_queue [$];
  sky_vec_t sky_expected [$];
  int       send_idle_pct;
  int       recv_stall_pct;
  int       stall_left;
  int       mismatches;
  int       cycle_count;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic longint round_shift16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // divide by the norm, round half away from zero, clamp to +-1.0
  function automatic logic signed [SKY_W-1:0] normalize_lane(longint num,
                                                              longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    longint          r;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q   = ((mag << 5) + den) / (den << 1);
    if (q > 64'd1048576) q = 64'd1048576;
    r = (num < 0) ? -longint'(q) : longint'(q);
    return r[SKY_W-1:0];
  endfunction

  function automatic sky_vec_t project_corner(corner_t c);
    longint x, y, cr, sr, ct, st, cs, ss;
    longint rx, ry, sx, sy, sz, ox, oy;
    longint unsigned den;
    sky_vec_t v;
    x  = c.point_x;
    y  = c.point_y;
    cr = trig_regs[REG_COS_ROT];
    sr = trig_regs[REG_SIN_ROT];
    ct = trig_regs[REG_COS_TILT];
    st = trig_regs[REG_SIN_TILT];
    cs = trig_regs[REG_COS_SPIN];
    ss = trig_regs[REG_SIN_SPIN];
    rx = round_shift16(cr * x + sr * y);
    ry = round_shift16(cr * y - sr * x);
    den = floor_sqrt(longint'(rx * rx) + longint'(ry * ry) + (64'd1 << 40));
    sx = rx * 65536;
    sy = ry * ct - 64'sd1048576 * st;
    sz = ry * st + 64'sd1048576 * ct;
    ox = round_shift16(sx * cs - sy * ss);
    oy = round_shift16(sx * ss + sy * cs);
    v.sky_x = normalize_lane(ox, den);
    v.sky_y = normalize_lane(oy, den);
    v.sky_z = normalize_lane(sz, den);
    return v;
  endfunction

  // point driver: hold a beat until taken, then maybe idle
  always @(posedge clk) begin
    corner_t c;
    if (!rst_n) begin
      pt_if.valid <= 1'b0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        c.point_x = pt_if.point_x;
        c.point_y = pt_if.point_y;
        sky_expected.push_back(project_corner(c));
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (corner_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = corner_queue.pop_front();
          pt_if.valid   <= 1'b1;
          pt_if.point_x <= c.point_x;
          pt_if.point_y <= c.point_y;
        end else begin
          pt_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (stall_left > 0) stall_left <= stall_left - 1;
  end

  // result monitor: random back-pressure and compare against oldest prediction
  always @(posedge clk) begin
    sky_vec_t e;
    if (!rst_n) begin
      sky_if.ready <= 1'b0;
    end else begin
      if (sky_if.valid && sky_if.ready) begin
        if (sky_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected vector beat %0d %0d %0d",
                     sky_if.sky_x, sky_if.sky_y, sky_if.sky_z);
        end else begin
          e = sky_expected.pop_front();
          if (e.sky_x !== sky_if.sky_x || e.sky_y !== sky_if.sky_y ||
              e.sky_z !== sky_if.sky_z) begin
            mismatches++;
            if (mismatches <= 10)
              $display("vector mismatch: exp %0d %0d %0d got %0d %0d %0d",
                       e.sky_x, e.sky_y, e.sky_z,
                       sky_if.sky_x, sky_if.sky_y, sky_if.sky_z);
          end
        end
      end
      sky_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_trig(logic [CFG_IDX_W-1:0] idx, logic signed [TRIG_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx <= REG_SIN_SPIN) trig_regs[idx] = val;
  endtask

  task automatic write_trig_set(logic signed [TRIG_W-1:0] cr, sr, ct, st, cs, ss);
    write_trig(REG_COS_ROT, cr);
    write_trig(REG_SIN_ROT, sr);
    write_trig(REG_COS_TILT, ct);
    write_trig(REG_SIN_TILT, st);
    write_trig(REG_COS_SPIN, cs);
    write_trig(REG_SIN_SPIN, ss);
  endtask

  // wait for the pipeline to drain fully
  task automatic wait_quiet();
    while (corner_queue.size() != 0 || pt_if.valid || sky_expected.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_corner(logic signed [POINT_W-1:0] px, py);
    corner_t c;
    c.point_x = px;
    c.point_y = py;
    corner_queue.push_back(c);
  endtask

  // mostly in-field points, some across the full Q3.20 range
  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0)
        push_corner($signed(24'($urandom)), $signed(24'($urandom)));
      else
        push_corner($signed(24'($urandom_range(2097152))) - 24'sd1048576,
                    $signed(24'($urandom_range(2097152))) - 24'sd1048576);
    end
  endtask

  function automatic logic signed [TRIG_W-1:0] rand_trig();
    return $signed(TRIG_W'($urandom_range(131072))) - 18'sd65536;
  endfunction

  initial begin
    logic signed [POINT_W-1:0] ext [5];
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_left     = 0;
    mismatches     = 0;
    cycle_count    = 0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    pt_if.valid    = 1'b0;
    pt_if.point_x  = '0;
    pt_if.point_y  = '0;
    sky_if.ready   = 1'b0;
    trig_regs[REG_COS_ROT]  = TRIG_ONE;
    trig_regs[REG_SIN_ROT]  = TRIG_ZERO;
    trig_regs[REG_COS_TILT] = TRIG_ONE;
    trig_regs[REG_SIN_TILT] = TRIG_ZERO;
    trig_regs[REG_COS_SPIN] = TRIG_ONE;
    trig_regs[REG_SIN_SPIN] = TRIG_ZERO;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes under reset trig values
    ext = '{-24'sd8388608, 24'sd8388607, 24'sd0, 24'sd1048576, -24'sd1};
    foreach (ext[i]) foreach (ext[j]) push_corner(ext[i], ext[j]);
    wait_quiet();

    // unnormalized trig extremes, then ignored indexes
    write_trig_set(-18'sd131072, 18'sd131071, -18'sd131072, 18'sd131071,
                   -18'sd131072, 18'sd131071);
    write_trig(3'd6, 18'sd12345);
    write_trig(3'd7, -18'sd1);
    foreach (ext[i]) push_corner(ext[i], ext[4 - i]);
    push_random(15);
    wait_quiet();

    for (int phase = 0; phase < 10; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      case (phase)
        0: write_trig_set(TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO);
        1: write_trig_set(TRIG_ZERO, TRIG_ONE, TRIG_ZERO, -18'sd65536,
                          -18'sd65536, TRIG_ZERO);
        2: write_trig_set(18'sd46341, 18'sd46341, 18'sd56756, 18'sd32768,
                          18'sd32768, -18'sd56756);
        3: write_trig_set(-18'sd131072, -18'sd131072, 18'sd131071, 18'sd131071,
                          -18'sd131072, -18'sd131072);
        default: write_trig_set(rand_trig(), rand_trig(), rand_trig(), rand_trig(),
                                rand_trig(), rand_trig());
      endcase
      // back up the output while the driver keeps offering points
      if (phase == 4) stall_left = 500;
      push_random(110);
      wait_quiet();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_quiet();
    if (mismatches == 0 && sky_expected.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/tpsv_pkg.sv
rtl/core/tpsv_point_if.sv
rtl/core/tpsv_sky_if.sv
rtl/core/tpsv_cfg_if.sv
rtl/core/tpsv_front.sv
rtl/core/tpsv_root_step.sv
rtl/core/tpsv_div_step.sv
rtl/core/tangent_plane_to_sky_vector.sv
bench/tangent_plane_to_sky_vector_tb.sv
